### rtl/core/radix_digits_with_palindrome_flag_unit_defines.svh
// Assertion macros used by the checker of the radix digit unit.
`ifndef RADIX_DIGITS_WITH_PALINDROME_FLAG_UNIT_DEFINES_SVH
`define RADIX_DIGITS_WITH_PALINDROME_FLAG_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RDPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RDPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rdpf_pkg.sv
// Package with the shared constants, types and functions of the radix digit unit.
`default_nettype none

package rdpf_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 32;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 5;
  localparam int CHAR_W  = 7;
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W  = $clog2(MAX_DIGITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(20);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX   = DIGIT_W'(19);
  localparam logic [DIGIT_W-1:0] DEC_MAX     = DIGIT_W'(9);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = CHAR_W'(65);

  // Divider: DIV_STEP quotient bits per cycle.
  localparam int DIV_STEP   = 8;
  localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_PAD_W  = DIV_CYCLES * DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]     radix;
  } job_t;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [RADIX_W-1:0]     radix;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d <= DEC_MAX) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_ALPHA + CHAR_W'(d) - CHAR_W'(DEC_MAX) - CHAR_W'(1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/rdpf_ram.sv
// Generic RAM with one write port and two enabled, registered read ports.
`default_nettype none

module rdpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

### rtl/core/rdpf_div.sv
// Iterative divider of a value by a small radix, several quotient bits per cycle.
`default_nettype none

module rdpf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rdpf_pkg::div_req_t req,
  output rdpf_pkg::div_rsp_t rsp
);
  import rdpf_pkg::*;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_PAD_W-1:0]   sh_r, sh_nxt;
  logic [RADIX_W-1:0]     rem_r, rem_nxt;
  logic [RADIX_W-1:0]     r_r, r_nxt;

  // Restoring division, DIV_STEP bits per cycle. The shift register takes
  // in quotient bits at the bottom as dividend bits leave at the top.
  always_comb begin
    logic [DIV_PAD_W-1:0] sh;
    logic [RADIX_W-1:0]   rem;
    logic [RADIX_W:0]     t;
    sh       = sh_r;
    rem      = rem_r;
    t        = '0;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    r_nxt    = r_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_CYCLES);
      sh_nxt   = DIV_PAD_W'(req.dividend);
      rem_nxt  = '0;
      r_nxt    = req.radix;
    end else if (busy_r) begin
      for (int i = 0; i < DIV_STEP; i++) begin
        t  = {rem, sh[DIV_PAD_W-1]};
        sh = {sh[DIV_PAD_W-2:0], 1'b0};
        if (t >= {1'b0, r_r}) begin
          t     = t - {1'b0, r_r};
          sh[0] = 1'b1;
        end
        rem = t[RADIX_W-1:0];
      end
      sh_nxt  = sh;
      rem_nxt = rem;
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    r_r   <= r_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = sh_r[VALUE_WIDTH-1:0];
  assign rsp.remainder = DIGIT_W'(rem_r);

endmodule

`default_nettype wire

### rtl/core/rdpf_front.sv
// Front end: radix register, input acceptance with radix clamping, job queue.
`default_nettype none

module rdpf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [rdpf_pkg::RADIX_W-1:0]     cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rdpf_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                             job_valid,
  output rdpf_pkg::job_t                   job,
  input  logic                             job_pop
);
  import rdpf_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] radix_eff;
  job_t               q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               push;
  logic               pop;

  // Out-of-range radix settings fold onto the nearest legal base.
  always_comb begin
    if (radix_r < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_r;
    end
  end

  assign in_ready  = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt_r != '0);
  assign pop       = job_pop && job_valid;
  assign job       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= RADIX_RESET;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        radix_r <= cfg_wr_data;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= '{value: in_value, radix: radix_eff};
    end
  end

endmodule

`default_nettype wire

### rtl/core/rdpf_back.sv
// Back end: digit extraction into the digit store, palindrome scan and digit output.
`default_nettype none

module rdpf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  rdpf_pkg::job_t                job,
  output logic                          job_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rdpf_pkg::DIGIT_W-1:0]  out_digit,
  output logic [rdpf_pkg::CHAR_W-1:0]   out_char_code,
  output logic                          out_is_palindrome,
  output logic                          out_last_digit
);
  import rdpf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt, n_inc;
  logic               pal_r, pal_nxt;
  logic [ADDR_W-1:0]  lo_r, lo_nxt;
  logic [ADDR_W-1:0]  hi_r, hi_nxt;
  logic               cmp_pend_r, cmp_pend_nxt;
  logic [ADDR_W-1:0]  e_addr_r, e_addr_nxt;
  logic [CNT_W-1:0]   emit_left_r, emit_left_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               rd_last_r, rd_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DIGIT_W-1:0] out_digit_r, out_digit_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_pal_r, out_pal_nxt;
  logic               out_last_r, out_last_nxt;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic               ram_re_a, ram_re_b;
  logic [ADDR_W-1:0]  ram_raddr_a, ram_raddr_b;
  logic [DIGIT_W-1:0] ram_rdata_a, ram_rdata_b;
  logic               out_load;
  logic               issue;

  rdpf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rdpf_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (div_rsp.remainder),
    .re_a    (ram_re_a),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .re_b    (ram_re_b),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  assign n_inc     = n_r + CNT_W'(1);
  assign ram_waddr = n_r[ADDR_W-1:0];
  // The store's read register feeds the output register; it moves on when
  // the output register is empty or being taken.
  assign out_load  = rd_pend_r && (!out_valid_r || out_ready);
  assign issue     = (state_r == S_EMIT) && (emit_left_r != '0) && (!rd_pend_r || out_load);

  always_comb begin
    state_nxt        = state_r;
    radix_nxt        = radix_r;
    n_nxt            = n_r;
    pal_nxt          = pal_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    cmp_pend_nxt     = cmp_pend_r;
    e_addr_nxt       = e_addr_r;
    emit_left_nxt    = emit_left_r;
    rd_pend_nxt      = rd_pend_r;
    rd_last_nxt      = rd_last_r;
    out_valid_nxt    = out_valid_r;
    out_digit_nxt    = out_digit_r;
    out_char_nxt     = out_char_r;
    out_pal_nxt      = out_pal_r;
    out_last_nxt     = out_last_r;
    job_pop          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = job.value;
    div_req.radix    = job.radix;
    ram_we           = 1'b0;
    ram_re_a         = 1'b0;
    ram_re_b         = 1'b0;
    ram_raddr_a      = e_addr_r;
    ram_raddr_b      = hi_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_digit_nxt = ram_rdata_a;
      out_char_nxt  = char_of(ram_rdata_a);
      out_pal_nxt   = pal_r;
      out_last_nxt  = rd_last_r;
      rd_pend_nxt   = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop       = 1'b1;
          div_req.start = 1'b1;
          radix_nxt     = job.radix;
          n_nxt         = '0;
          pal_nxt       = 1'b1;
          state_nxt     = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (div_rsp.done) begin
          ram_we = 1'b1;
          n_nxt  = n_inc;
          if (div_rsp.quotient == '0 || n_inc == CNT_W'(MAX_DIGITS)) begin
            lo_nxt       = '0;
            hi_nxt       = n_r[ADDR_W-1:0];
            cmp_pend_nxt = 1'b0;
            state_nxt    = S_CHECK;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
            div_req.radix    = radix_r;
          end
        end
      end
      S_CHECK: begin
        // Both ends of the digit string are read together and compared in the
        // cycle after, walking inward.
        if (cmp_pend_r && (ram_rdata_a != ram_rdata_b)) begin
          pal_nxt = 1'b0;
        end
        cmp_pend_nxt = 1'b0;
        if (lo_r < hi_r) begin
          ram_re_a     = 1'b1;
          ram_re_b     = 1'b1;
          ram_raddr_a  = lo_r;
          lo_nxt       = lo_r + ADDR_W'(1);
          hi_nxt       = hi_r - ADDR_W'(1);
          cmp_pend_nxt = 1'b1;
        end else if (!cmp_pend_r) begin
          e_addr_nxt    = n_r[ADDR_W-1:0] - ADDR_W'(1);
          emit_left_nxt = n_r;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (issue) begin
          ram_re_a      = 1'b1;
          e_addr_nxt    = e_addr_r - ADDR_W'(1);
          emit_left_nxt = emit_left_r - CNT_W'(1);
          rd_pend_nxt   = 1'b1;
          rd_last_nxt   = (emit_left_r == CNT_W'(1));
        end
        if (out_load && rd_last_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      cmp_pend_r  <= 1'b0;
      emit_left_r <= '0;
      rd_pend_r   <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      cmp_pend_r  <= cmp_pend_nxt;
      emit_left_r <= emit_left_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    radix_r     <= radix_nxt;
    pal_r       <= pal_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    e_addr_r    <= e_addr_nxt;
    out_digit_r <= out_digit_nxt;
    out_char_r  <= out_char_nxt;
    out_pal_r   <= out_pal_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_digit         = out_digit_r;
  assign out_char_code     = out_char_r;
  assign out_is_palindrome = out_pal_r;
  assign out_last_digit    = out_last_r;

endmodule

`default_nettype wire

### rtl/core/radix_digits_with_palindrome_flag_unit.sv
// Top level of the radix digit unit: front end, job queue and back end.
//
// The input channel (in_valid, in_ready, in_value) takes one unsigned value per
// item. For each value the output channel (out_valid, out_ready) gives one item
// per digit in the base held in the radix register, most significant digit
// first, with its character code, the palindrome flag of the whole digit string
// and a mark on the final digit. Zero gives the single digit 0.
// The radix register is written through cfg_wr_en and cfg_wr_data, by the user
// only while the unit is idle (the unit does not enforce this); settings below
// 2 act as 2 and above 20 act as 20. Each digit of a value comes from the
// iterative divider, the palindrome scan then runs over the two read ports of
// the digit store, and the digits leave at one per cycle when out_ready stays
// high, each passing through the store's read register and the output register.
// A two-entry queue behind the input lets new values arrive while a conversion
// runs. When the receiver stalls, the output item holds and the back end waits.
// Reset (rst_n low, synchronous) empties the queue, drops any conversion in
// progress and sets the radix to 10.
`default_nettype none

module radix_digits_with_palindrome_flag_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [rdpf_pkg::RADIX_W-1:0]     cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rdpf_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rdpf_pkg::DIGIT_W-1:0]     out_digit,
  output logic [rdpf_pkg::CHAR_W-1:0]      out_char_code,
  output logic                             out_is_palindrome,
  output logic                             out_last_digit
);
  import rdpf_pkg::*;

  logic job_valid;
  logic job_pop;
  job_t job;

  rdpf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value    (in_value),
    .job_valid   (job_valid),
    .job         (job),
    .job_pop     (job_pop)
  );

  rdpf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (job_valid),
    .job               (job),
    .job_pop           (job_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digit         (out_digit),
    .out_char_code     (out_char_code),
    .out_is_palindrome (out_is_palindrome),
    .out_last_digit    (out_last_digit)
  );

endmodule

`default_nettype wire

### rtl/core/rdpf_checker.sv
// Port-level checker for the radix digit unit and its bind to the top level.
`default_nettype none
`include "radix_digits_with_palindrome_flag_unit_defines.svh"

module rdpf_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [rdpf_pkg::DIGIT_W-1:0] out_digit,
  input wire logic [rdpf_pkg::CHAR_W-1:0]  out_char_code,
  input wire logic                         out_is_palindrome,
  input wire logic                         out_last_digit
);
  import rdpf_pkg::*;

  // A stalled output item keeps all of its fields.
  `RDPF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_digit) && $stable(out_char_code) && $stable(out_is_palindrome) && $stable(out_last_digit), "output item changed while stalled")

  // The character code always matches the digit it travels with.
  `RDPF_ASSERT_NOW(a_char_match, out_valid, out_char_code == char_of(out_digit), "character code does not match digit")

  // No digit reaches the largest base or beyond.
  `RDPF_ASSERT_NOW(a_digit_range, out_valid, out_digit <= DIGIT_MAX, "digit out of range")

  // Nothing is offered in the first cycle after reset.
  `RDPF_ASSERT_NOW(a_quiet_after_reset, $past(!rst_n), !out_valid, "output valid right after reset")

endmodule

bind radix_digits_with_palindrome_flag_unit rdpf_checker u_rdpf_checker (.*);

`default_nettype wire
